// File: rtl/scc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the SCC core.
`default_nettype none

package scc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = VW + 1;
    localparam int AW = 2 * VW;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_FIND   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_EXISTS  = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_RESP,
        DP_ADD,
        DP_CLEAR,
        DP_REM,
        DP_RM_RD,
        DP_RM_CHK,
        DP_F_INIT,
        DP_F_OUTER,
        DP_F_STEP,
        DP_F_ARC,
        DP_S_INIT,
        DP_S_ROOT,
        DP_S_PUSH,
        DP_S_POP,
        DP_S_END,
        DP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       range_err;
        logic       arc_exists;
        logic       scan_done;
        logic       outer_done;
        logic       stack_empty;
        logic       stack_one;
        logic       top_more;
        logic       fin_empty;
        logic       root_ok;
        logic       cand_any;
        logic       can_emit;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/scc_ctrl.sv
// Sequencing state machine for the SCC core.
`default_nettype none

module scc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire scc_pkg::stat_t stat,
    output scc_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RESP,
        S_RM_RD,
        S_RM_CHK,
        S_F_OUTER,
        S_F_STEP,
        S_F_ARC,
        S_S_INIT,
        S_S_ROOT,
        S_S_STEP,
        S_S_END,
        S_FLUSH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] resp_st_reg, resp_st_next;

    always_comb begin
        state_next   = state_reg;
        resp_st_next = resp_st_reg;
        s_ready      = 1'b0;
        cmd.op       = scc_pkg::DP_NOP;
        cmd.status   = resp_st_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = scc_pkg::DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_RESP;
                unique case (stat.req)
                    scc_pkg::REQ_CLEAR: begin
                        cmd.op       = scc_pkg::DP_CLEAR;
                        resp_st_next = scc_pkg::ST_OK;
                    end
                    scc_pkg::REQ_FIND: begin
                        cmd.op     = scc_pkg::DP_F_INIT;
                        state_next = S_F_OUTER;
                    end
                    scc_pkg::REQ_ADD: begin
                        if (stat.range_err) begin
                            resp_st_next = scc_pkg::ST_RANGE;
                        end else if (stat.arc_exists) begin
                            resp_st_next = scc_pkg::ST_EXISTS;
                        end else begin
                            cmd.op       = scc_pkg::DP_ADD;
                            resp_st_next = scc_pkg::ST_OK;
                        end
                    end
                    default: begin
                        if (stat.range_err) begin
                            resp_st_next = scc_pkg::ST_RANGE;
                        end else if (!stat.arc_exists) begin
                            resp_st_next = scc_pkg::ST_MISSING;
                        end else begin
                            state_next = S_RM_RD;
                        end
                    end
                endcase
            end
            S_RM_RD: begin
                if (stat.scan_done) begin
                    cmd.op       = scc_pkg::DP_REM;
                    resp_st_next = scc_pkg::ST_OK;
                    state_next   = S_RESP;
                end else begin
                    cmd.op     = scc_pkg::DP_RM_RD;
                    state_next = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                cmd.op     = scc_pkg::DP_RM_CHK;
                state_next = S_RM_RD;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.op     = scc_pkg::DP_RESP;
                    state_next = S_IDLE;
                end
            end
            S_F_OUTER: begin
                if (stat.outer_done) begin
                    state_next = S_S_INIT;
                end else begin
                    cmd.op     = scc_pkg::DP_F_OUTER;
                    state_next = S_F_STEP;
                end
            end
            S_F_STEP: begin
                if (stat.stack_empty) begin
                    state_next = S_F_OUTER;
                end else begin
                    cmd.op = scc_pkg::DP_F_STEP;
                    if (stat.top_more) begin
                        state_next = S_F_ARC;
                    end
                end
            end
            S_F_ARC: begin
                cmd.op     = scc_pkg::DP_F_ARC;
                state_next = S_F_STEP;
            end
            S_S_INIT: begin
                cmd.op     = scc_pkg::DP_S_INIT;
                state_next = S_S_ROOT;
            end
            S_S_ROOT: begin
                if (stat.fin_empty) begin
                    state_next = S_FLUSH;
                end else if (!stat.root_ok) begin
                    cmd.op = scc_pkg::DP_S_ROOT;
                end else if (stat.can_emit) begin
                    cmd.op     = scc_pkg::DP_S_ROOT;
                    state_next = S_S_STEP;
                end
            end
            S_S_STEP: begin
                if (stat.cand_any) begin
                    if (stat.can_emit) begin
                        cmd.op = scc_pkg::DP_S_PUSH;
                    end
                end else begin
                    cmd.op = scc_pkg::DP_S_POP;
                    if (stat.stack_one) begin
                        state_next = S_S_END;
                    end
                end
            end
            S_S_END: begin
                cmd.op     = scc_pkg::DP_S_END;
                state_next = S_S_ROOT;
            end
            S_FLUSH: begin
                if (stat.out_free) begin
                    cmd.op     = scc_pkg::DP_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            resp_st_reg <= scc_pkg::ST_OK;
        end else begin
            state_reg   <= state_next;
            resp_st_reg <= resp_st_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/scc_dpath.sv
// Graph storage, walk stacks and result registers of the SCC core.
`default_nettype none

module scc_dpath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire scc_pkg::cmd_t        cmd,
    output scc_pkg::stat_t            stat,
    input  wire logic                 cfg_we,
    input  wire logic [5:0]           cfg_data,
    input  wire logic [1:0]           s_req_type,
    input  wire logic [5:0]           s_src_vertex,
    input  wire logic [5:0]           s_dst_vertex,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [4:0]                m_member_vertex,
    output logic [4:0]                m_component_index,
    output logic                      m_last_of_component,
    output logic                      m_last_of_run
);

    localparam int MAXV = scc_pkg::MAX_VERTICES;
    localparam int VW   = scc_pkg::VW;
    localparam int CW   = scc_pkg::CW;
    localparam int AW   = scc_pkg::AW;

    // Configuration and the latched request.
    logic [5:0]    vcount_reg;
    logic [CW-1:0] n_act;
    logic [1:0]    req_reg;
    logic          range_err_reg;
    logic [VW-1:0] u_reg, v_reg;
    logic [CW-1:0] i_reg;
    logic          found_reg;

    // Graph: ordered successor lists in memory, counts and predecessor rows in flops.
    logic [VW-1:0]   list_mem [1 << AW];
    logic [VW-1:0]   rdata_reg;
    logic [CW-1:0]   cnt_reg  [MAXV];
    logic [MAXV-1:0] pred_reg [MAXV];

    // Walk state.
    logic [MAXV-1:0] visited_reg;
    logic [VW-1:0]   stk_v_reg [MAXV];
    logic [CW-1:0]   stk_p_reg [MAXV];
    logic [CW-1:0]   sp_reg;
    logic [VW-1:0]   fin_reg [MAXV];
    logic [CW-1:0]   fp_reg;
    logic [CW-1:0]   s_reg;
    logic [4:0]      comp_reg;

    // Member waiting until we know whether it ends its component.
    logic       held_v_reg;
    logic [4:0] held_vtx_reg;
    logic [4:0] held_comp_reg;
    logic       held_last_reg;

    logic       m_valid_reg;
    logic [1:0] m_status_reg;
    logic [4:0] m_vtx_reg, m_comp_reg;
    logic       m_lc_reg, m_lr_reg;

    logic [VW-1:0]   top_idx, top_v, cnt_idx, pred_idx, fin_top, cand_u, emit_vtx;
    logic [CW-1:0]   top_p, cnt_sel;
    logic [MAXV-1:0] pred_row, nmask, cand;
    logic            out_free, w_new, root_ok, emit, out_load;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [VW-1:0]   mem_wd;

    always_comb begin
        if (vcount_reg == 6'd0) begin
            n_act = CW'(1);
        end else if (7'(vcount_reg) > 7'(MAXV)) begin
            n_act = CW'(MAXV);
        end else begin
            n_act = CW'(vcount_reg);
        end
    end

    assign top_idx  = VW'(sp_reg - CW'(1));
    assign top_v    = stk_v_reg[top_idx];
    assign top_p    = stk_p_reg[top_idx];
    assign cnt_idx  = (req_reg == scc_pkg::REQ_FIND) ? top_v : u_reg;
    assign pred_idx = (req_reg == scc_pkg::REQ_FIND) ? top_v : v_reg;
    assign cnt_sel  = cnt_reg[cnt_idx];
    assign pred_row = pred_reg[pred_idx];
    assign fin_top  = fin_reg[VW'(fp_reg - CW'(1))];
    assign out_free = !m_valid_reg || m_ready;
    assign w_new    = (CW'(rdata_reg) < n_act) && !visited_reg[rdata_reg];
    assign root_ok  = (CW'(fin_top) < n_act) && !visited_reg[fin_top];

    always_comb begin
        for (int k = 0; k < MAXV; k++) begin
            nmask[k] = (7'(k) < 7'(n_act));
        end
    end

    assign cand = pred_row & ~visited_reg & nmask;

    always_comb begin
        cand_u = '0;
        for (int k = MAXV - 1; k >= 0; k--) begin
            if (cand[k]) begin
                cand_u = VW'(k);
            end
        end
    end

    assign emit     = (cmd.op == scc_pkg::DP_S_PUSH) ||
                      ((cmd.op == scc_pkg::DP_S_ROOT) && root_ok);
    assign emit_vtx = (cmd.op == scc_pkg::DP_S_PUSH) ? cand_u : fin_top;

    // The output register takes a new item in this cycle.
    assign out_load = (emit && held_v_reg) || (cmd.op == scc_pkg::DP_RESP) ||
                      (cmd.op == scc_pkg::DP_FLUSH);

    always_comb begin
        stat.req         = req_reg;
        stat.range_err   = range_err_reg;
        stat.arc_exists  = pred_row[u_reg];
        stat.scan_done   = (i_reg >= cnt_sel);
        stat.outer_done  = (s_reg >= n_act);
        stat.stack_empty = (sp_reg == '0);
        stat.stack_one   = (sp_reg == CW'(1));
        stat.top_more    = (top_p < cnt_sel);
        stat.fin_empty   = (fp_reg == '0);
        stat.root_ok     = root_ok;
        stat.cand_any    = |cand;
        stat.can_emit    = !held_v_reg || out_free;
        stat.out_free    = out_free;
    end

    // Memory port selection.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = {u_reg, cnt_sel[VW-1:0]};
        mem_wd = v_reg;
        mem_re = 1'b0;
        mem_ra = {u_reg, i_reg[VW-1:0]};
        case (cmd.op)
            scc_pkg::DP_ADD: begin
                mem_we = 1'b1;
            end
            scc_pkg::DP_RM_RD: begin
                mem_re = 1'b1;
            end
            scc_pkg::DP_RM_CHK: begin
                mem_we = found_reg && (rdata_reg != v_reg);
                mem_wa = {u_reg, VW'(i_reg - CW'(1))};
                mem_wd = rdata_reg;
            end
            scc_pkg::DP_F_STEP: begin
                mem_re = stat.top_more;
                mem_ra = {top_v, top_p[VW-1:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            list_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= list_mem[mem_ra];
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            scc_pkg::DP_LOAD: begin
                req_reg       <= s_req_type;
                range_err_reg <= (s_src_vertex == 6'd0) || (7'(s_src_vertex) > 7'(n_act)) ||
                                 (s_dst_vertex == 6'd0) || (7'(s_dst_vertex) > 7'(n_act));
                u_reg         <= VW'(s_src_vertex - 6'd1);
                v_reg         <= VW'(s_dst_vertex - 6'd1);
                i_reg         <= '0;
                found_reg     <= 1'b0;
            end
            scc_pkg::DP_RM_CHK: begin
                if (rdata_reg == v_reg) begin
                    found_reg <= 1'b1;
                end
                i_reg <= i_reg + CW'(1);
            end
            scc_pkg::DP_F_OUTER: begin
                if (!visited_reg[s_reg[VW-1:0]]) begin
                    stk_v_reg[sp_reg[VW-1:0]] <= s_reg[VW-1:0];
                    stk_p_reg[sp_reg[VW-1:0]] <= '0;
                end
            end
            scc_pkg::DP_F_STEP: begin
                if (stat.top_more) begin
                    stk_p_reg[top_idx] <= top_p + CW'(1);
                end else begin
                    fin_reg[fp_reg[VW-1:0]] <= top_v;
                end
            end
            scc_pkg::DP_F_ARC: begin
                if (w_new) begin
                    stk_v_reg[sp_reg[VW-1:0]] <= rdata_reg;
                    stk_p_reg[sp_reg[VW-1:0]] <= '0;
                end
            end
            scc_pkg::DP_S_ROOT: begin
                if (root_ok) begin
                    stk_v_reg[sp_reg[VW-1:0]] <= fin_top;
                end
            end
            scc_pkg::DP_S_PUSH: begin
                stk_v_reg[sp_reg[VW-1:0]] <= cand_u;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg  <= 6'(MAXV);
            visited_reg <= '0;
            sp_reg      <= '0;
            fp_reg      <= '0;
            s_reg       <= '0;
            comp_reg    <= '0;
            held_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < MAXV; k++) begin
                cnt_reg[k]  <= '0;
                pred_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) begin
                vcount_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit) begin
                if (held_v_reg) begin
                    m_status_reg <= scc_pkg::ST_OK;
                    m_vtx_reg    <= held_vtx_reg;
                    m_comp_reg   <= held_comp_reg;
                    m_lc_reg     <= held_last_reg;
                    m_lr_reg     <= 1'b0;
                end
                held_v_reg    <= 1'b1;
                held_vtx_reg  <= 5'(emit_vtx);
                held_comp_reg <= comp_reg;
                held_last_reg <= 1'b0;
                visited_reg[emit_vtx] <= 1'b1;
                sp_reg        <= sp_reg + CW'(1);
            end
            case (cmd.op)
                scc_pkg::DP_RESP: begin
                    m_status_reg <= cmd.status;
                    m_vtx_reg    <= '0;
                    m_comp_reg   <= '0;
                    m_lc_reg     <= 1'b0;
                    m_lr_reg     <= 1'b1;
                end
                scc_pkg::DP_ADD: begin
                    cnt_reg[u_reg]         <= cnt_sel + CW'(1);
                    pred_reg[v_reg][u_reg] <= 1'b1;
                end
                scc_pkg::DP_REM: begin
                    cnt_reg[u_reg]         <= cnt_sel - CW'(1);
                    pred_reg[v_reg][u_reg] <= 1'b0;
                end
                scc_pkg::DP_CLEAR: begin
                    for (int k = 0; k < MAXV; k++) begin
                        cnt_reg[k]  <= '0;
                        pred_reg[k] <= '0;
                    end
                end
                scc_pkg::DP_F_INIT: begin
                    visited_reg <= '0;
                    sp_reg      <= '0;
                    fp_reg      <= '0;
                    s_reg       <= '0;
                    comp_reg    <= '0;
                    held_v_reg  <= 1'b0;
                end
                scc_pkg::DP_F_OUTER: begin
                    if (!visited_reg[s_reg[VW-1:0]]) begin
                        visited_reg[s_reg[VW-1:0]] <= 1'b1;
                        sp_reg <= sp_reg + CW'(1);
                    end
                    s_reg <= s_reg + CW'(1);
                end
                scc_pkg::DP_F_STEP: begin
                    if (!stat.top_more) begin
                        sp_reg <= sp_reg - CW'(1);
                        fp_reg <= fp_reg + CW'(1);
                    end
                end
                scc_pkg::DP_F_ARC: begin
                    if (w_new) begin
                        visited_reg[rdata_reg] <= 1'b1;
                        sp_reg <= sp_reg + CW'(1);
                    end
                end
                scc_pkg::DP_S_INIT: begin
                    visited_reg <= '0;
                end
                scc_pkg::DP_S_ROOT: begin
                    fp_reg <= fp_reg - CW'(1);
                end
                scc_pkg::DP_S_POP: begin
                    sp_reg <= sp_reg - CW'(1);
                end
                scc_pkg::DP_S_END: begin
                    held_last_reg <= 1'b1;
                    comp_reg      <= comp_reg + 5'd1;
                end
                scc_pkg::DP_FLUSH: begin
                    m_status_reg <= scc_pkg::ST_OK;
                    m_vtx_reg    <= held_vtx_reg;
                    m_comp_reg   <= held_comp_reg;
                    m_lc_reg     <= held_last_reg;
                    m_lr_reg     <= 1'b1;
                    held_v_reg   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_member_vertex     = m_vtx_reg;
    assign m_component_index   = m_comp_reg;
    assign m_last_of_component = m_lc_reg;
    assign m_last_of_run       = m_lr_reg;

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sp_reg <= CW'(MAXV)) && (fp_reg <= CW'(MAXV)))
        else $error("walk stack or finish list beyond its depth");

    a_arc_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == scc_pkg::DP_F_ARC) |-> $past(cmd.op == scc_pkg::DP_F_STEP))
        else $error("arc examined without a list read before it");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && held_v_reg) |-> out_free)
        else $error("member emitted while the output register is occupied");

endmodule

`default_nettype wire

// File: rtl/strongly_connected_components_core.sv
// Top level of the strongly connected components core.
`default_nettype none

// Channel  | Ports                                              | Direction
// ---------+----------------------------------------------------+----------
// request  | s_valid, s_ready, s_req_type, s_src_vertex,        | in
//          | s_dst_vertex                                       |
// result   | m_valid, m_ready, m_status, m_member_vertex,       | out
//          | m_component_index, m_last_of_component,            |
//          | m_last_of_run                                      |
// config   | cfg_valid, cfg_ready, cfg_data (vertex count)      | in
//
// One item is processed at a time. Remove scans the source's successor list and
// compacts it through the successor list memory.
// A find makes a first depth-first pass (one list memory read per arc), then a
// second pass that picks the lowest unvisited predecessor from a bit row.
// Reset (aresetn low, synchronous) empties the graph and sets the vertex count
// to 32; the successor list memory needs no clearing pass.
// A stalled result channel holds the engine whenever a result item must enter
// the occupied output register: a single result, a member pushed out while one
// is held back awaiting its end-of-component flag, or the final member.

module strongly_connected_components_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_req_type,
    input  wire logic [5:0] s_src_vertex,
    input  wire logic [5:0] s_dst_vertex,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_status,
    output logic [4:0]      m_member_vertex,
    output logic [4:0]      m_component_index,
    output logic            m_last_of_component,
    output logic            m_last_of_run,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [5:0] cfg_data
);

    scc_pkg::cmd_t  cmd;
    scc_pkg::stat_t stat;

    // The vertex count register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    scc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scc_dpath u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg_valid && cfg_ready),
        .cfg_data            (cfg_data),
        .s_req_type          (s_req_type),
        .s_src_vertex        (s_src_vertex),
        .s_dst_vertex        (s_dst_vertex),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_member_vertex     (m_member_vertex),
        .m_component_index   (m_component_index),
        .m_last_of_component (m_last_of_component),
        .m_last_of_run       (m_last_of_run)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the strongly connected components core.
`timescale 1ns / 100ps

module tb;

    localparam int NV = 32;
    localparam int CYCLE_LIMIT = 2000000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_req_type = scc_pkg::REQ_CLEAR;
    logic [5:0] s_src_vertex = '0;
    logic [5:0] s_dst_vertex = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_status;
    logic [4:0] m_member_vertex;
    logic [4:0] m_component_index;
    logic       m_last_of_component;
    logic       m_last_of_run;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data = '0;

    strongly_connected_components_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_src_vertex(s_src_vertex), .s_dst_vertex(s_dst_vertex),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_member_vertex(m_member_vertex), .m_component_index(m_component_index),
        .m_last_of_component(m_last_of_component), .m_last_of_run(m_last_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // One result item as it appears on the result channel.
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] member;
        logic [4:0] comp;
        logic       last_comp;
        logic       last_run;
    } member_rec_t;

    // Predictor state: the graph as the block should hold it.
    logic [4:0] succ_list [NV][NV];
    int         succ_cnt  [NV];
    logic [5:0] vcount_reg;
    member_rec_t pending_results[$];

    int errors = 0;
    int cycles = 0;
    bit hold_off = 1'b0;

    task automatic report(input string what, input int got, input int want);
        $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Append one expected result item at the tail of the queue.
    function automatic void add_expected(member_rec_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic int active_vertices();
        if (vcount_reg == 0) return 1;
        if (vcount_reg > NV) return NV;
        return vcount_reg;
    endfunction

    function automatic int arc_pos(int u, int v);
        for (int i = 0; i < succ_cnt[u]; i++)
            if (succ_list[u][i] == v) return i;
        return -1;
    endfunction

    function automatic member_rec_t single_rec(logic [1:0] st);
        member_rec_t r;
        r = '0;
        r.status = st;
        r.last_run = 1'b1;
        return r;
    endfunction

    // Kosaraju: forward DFS in list order for finish order, then DFS over the
    // transposed graph in reverse finish order, emitting members in preorder.
    task automatic predict_components();
        int n, sp, fp, k, comp, base;
        bit seen [NV];
        int stk_v [NV];
        int stk_p [NV];
        int fin [NV];
        n = active_vertices();
        fp = 0;
        k = 0;
        comp = 0;
        foreach (seen[i]) seen[i] = 0;
        for (int s = 0; s < n; s++) begin
            if (seen[s]) continue;
            seen[s] = 1;
            stk_v[0] = s; stk_p[0] = 0; sp = 1;
            while (sp > 0) begin
                int v;
                v = stk_v[sp-1];
                if (stk_p[sp-1] < succ_cnt[v]) begin
                    int w;
                    w = succ_list[v][stk_p[sp-1]];
                    stk_p[sp-1]++;
                    if (w < n && !seen[w] && sp < NV) begin
                        seen[w] = 1;
                        stk_v[sp] = w; stk_p[sp] = 0; sp++;
                    end
                end else begin
                    sp--;
                    if (fp < NV) begin
                        fin[fp] = v;
                        fp++;
                    end
                end
            end
        end
        foreach (seen[i]) seen[i] = 0;
        base = pending_results.size();
        while (fp > 0) begin
            int s;
            member_rec_t r;
            fp--;
            s = fin[fp];
            if (s >= n || seen[s]) continue;
            seen[s] = 1;
            r = '0; r.member = 5'(s); r.comp = 5'(comp);
            add_expected(r);
            k++;
            stk_v[0] = s; stk_p[0] = 0; sp = 1;
            while (sp > 0) begin
                int v;
                v = stk_v[sp-1];
                if (stk_p[sp-1] < n) begin
                    int u;
                    u = stk_p[sp-1];
                    stk_p[sp-1]++;
                    if (!seen[u] && arc_pos(u, v) >= 0 && sp < NV && k < NV) begin
                        seen[u] = 1;
                        r = '0; r.member = 5'(u); r.comp = 5'(comp);
                        add_expected(r);
                        k++;
                        stk_v[sp] = u; stk_p[sp] = 0; sp++;
                    end
                end else begin
                    sp--;
                end
            end
            pending_results[base + k - 1].last_comp = 1'b1;
            comp = (comp + 1) % 32;
        end
        if (k > 0) pending_results[base + k - 1].last_run = 1'b1;
    endtask

    task automatic predict_request(logic [1:0] req, logic [5:0] src, logic [5:0] dst);
        int n, u, v, p;
        n = active_vertices();
        if (req == scc_pkg::REQ_CLEAR) begin
            foreach (succ_cnt[i]) succ_cnt[i] = 0;
            add_expected(single_rec(scc_pkg::ST_OK));
        end else if (req == scc_pkg::REQ_FIND) begin
            predict_components();
        end else if (src < 1 || src > n || dst < 1 || dst > n) begin
            add_expected(single_rec(scc_pkg::ST_RANGE));
        end else begin
            u = src - 1;
            v = dst - 1;
            p = arc_pos(u, v);
            if (req == scc_pkg::REQ_ADD) begin
                if (p >= 0) begin
                    add_expected(single_rec(scc_pkg::ST_EXISTS));
                end else begin
                    if (succ_cnt[u] < NV) begin
                        succ_list[u][succ_cnt[u]] = 5'(v);
                        succ_cnt[u]++;
                    end
                    add_expected(single_rec(scc_pkg::ST_OK));
                end
            end else if (p < 0) begin
                add_expected(single_rec(scc_pkg::ST_MISSING));
            end else begin
                for (int i = p; i < succ_cnt[u] - 1; i++) succ_list[u][i] = succ_list[u][i+1];
                succ_cnt[u]--;
                add_expected(single_rec(scc_pkg::ST_OK));
            end
        end
    endtask

    // Checker: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result, member", m_member_vertex, 0);
            end else begin
                member_rec_t w;
                w = pending_results.pop_front();
                if (m_status !== w.status) report("status", m_status, w.status);
                if (m_member_vertex !== w.member)
                    report("member_vertex", m_member_vertex, w.member);
                if (m_component_index !== w.comp)
                    report("component_index", m_component_index, w.comp);
                if (m_last_of_component !== w.last_comp)
                    report("last_of_component", m_last_of_component, w.last_comp);
                if (m_last_of_run !== w.last_run)
                    report("last_of_run", m_last_of_run, w.last_run);
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Receiver: a stall pattern of its own, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            case (cycles % 64 < 32)
                1'b1: m_ready <= 1'b1;
                default: m_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic pressure_hold();
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    endtask

    // Offer one item, keeping valid up until accepted. Requests come in bursts with gaps between them.
    int burst_left = 0;
    task automatic send_request(logic [1:0] req, logic [5:0] src, logic [5:0] dst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_src_vertex <= src;
        s_dst_vertex <= dst;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_request(req, src, dst);
        burst_left--;
    endtask

    task automatic drain_block();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_vertex_count(logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        vcount_reg = value;
    endtask

    // Directed rows: request, source, destination, and an expected status
    // typed in for the obvious ones (-1 means taken from the predictor).
    typedef struct {
        logic [1:0] req;
        logic [5:0] src;
        logic [5:0] dst;
        int         want_status;
    } dir_row_t;

    dir_row_t dir_rows[19] = '{
        '{scc_pkg::REQ_FIND,   6'd0,  6'd0,  -1},
        '{scc_pkg::REQ_ADD,    6'd0,  6'd1,  scc_pkg::ST_RANGE},
        '{scc_pkg::REQ_ADD,    6'd1,  6'd33, scc_pkg::ST_RANGE},
        '{scc_pkg::REQ_ADD,    6'd63, 6'd63, scc_pkg::ST_RANGE},
        '{scc_pkg::REQ_REMOVE, 6'd1,  6'd2,  scc_pkg::ST_MISSING},
        '{scc_pkg::REQ_ADD,    6'd1,  6'd2,  scc_pkg::ST_OK},
        '{scc_pkg::REQ_ADD,    6'd1,  6'd2,  scc_pkg::ST_EXISTS},
        '{scc_pkg::REQ_ADD,    6'd2,  6'd3,  scc_pkg::ST_OK},
        '{scc_pkg::REQ_ADD,    6'd3,  6'd1,  scc_pkg::ST_OK},
        '{scc_pkg::REQ_ADD,    6'd32, 6'd32, scc_pkg::ST_OK},
        '{scc_pkg::REQ_ADD,    6'd1,  6'd32, scc_pkg::ST_OK},
        '{scc_pkg::REQ_ADD,    6'd1,  6'd5,  scc_pkg::ST_OK},
        '{scc_pkg::REQ_REMOVE, 6'd1,  6'd32, scc_pkg::ST_OK},
        '{scc_pkg::REQ_FIND,   6'd0,  6'd0,  -1},
        '{scc_pkg::REQ_REMOVE, 6'd3,  6'd1,  scc_pkg::ST_OK},
        '{scc_pkg::REQ_FIND,   6'd42, 6'd21, -1},
        '{scc_pkg::REQ_CLEAR,  6'd0,  6'd0,  scc_pkg::ST_OK},
        '{scc_pkg::REQ_REMOVE, 6'd1,  6'd2,  scc_pkg::ST_MISSING},
        '{scc_pkg::REQ_FIND,   6'd0,  6'd0,  -1}
    };

    // Random phase: mostly arcs among a few vertices so components form,
    // with finds and clears sprinkled in, plus some out-of-range noise.
    task automatic random_phase(int count, int nmax);
        for (int i = 0; i < count; i++) begin
            int sel;
            logic [5:0] a, b;
            sel = $urandom_range(0, 99);
            a = 6'($urandom_range(1, nmax));
            b = 6'($urandom_range(1, nmax));
            if (sel < 5) send_request(scc_pkg::REQ_CLEAR, 6'($urandom), 6'($urandom));
            else if (sel < 17) send_request(scc_pkg::REQ_FIND, 6'($urandom), 6'($urandom));
            else if (sel < 25)
                send_request(2'($urandom_range(0, 1)), 6'($urandom), 6'($urandom));
            else if (sel < 45) send_request(scc_pkg::REQ_REMOVE, a, b);
            else send_request(scc_pkg::REQ_ADD, a, b);
        end
    endtask

    initial begin
        vcount_reg = 6'd32;
        foreach (succ_cnt[i]) succ_cnt[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A row with a typed status causes one result, the newest expectation.
        foreach (dir_rows[i]) begin
            int last_idx;
            send_request(dir_rows[i].req, dir_rows[i].src, dir_rows[i].dst);
            last_idx = pending_results.size() - 1;
            if (dir_rows[i].want_status >= 0 &&
                pending_results[last_idx].status != dir_rows[i].want_status)
                report("directed row status", pending_results[last_idx].status,
                       dir_rows[i].want_status);
        end
        drain_block();

        // Register extremes: zero acts as one vertex, above the maximum acts as 32.
        write_vertex_count(6'd0);
        send_request(scc_pkg::REQ_ADD, 6'd1, 6'd1);
        send_request(scc_pkg::REQ_ADD, 6'd1, 6'd2);
        send_request(scc_pkg::REQ_FIND, 6'd0, 6'd0);
        drain_block();
        write_vertex_count(6'd63);
        random_phase(30, 32);
        drain_block();

        // Small graph: dense random arcs, long receiver hold-off midway.
        write_vertex_count(6'd6);
        random_phase(25, 7);
        fork
            pressure_hold();
            random_phase(15, 6);
        join
        drain_block();

        // Shrunk count keeps stored arcs; find ignores arcs beyond it.
        write_vertex_count(6'd1);
        random_phase(8, 3);
        drain_block();
        write_vertex_count(6'd12);
        random_phase(45, 12);
        send_request(scc_pkg::REQ_FIND, 6'd0, 6'd0);
        drain_block();

        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
